// ===== rtl/ddnp_pkg.sv =====
// Package for the differential drive nonlinear PID controller.
// Register indexes, widths, state machine type, divider request type and saturation constant.
`timescale 1ns / 1ps
`default_nettype none
package ddnp_pkg;
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned ADDR_W    = 5;
    localparam logic [2:0] REG_BASE = 3'd0;
    localparam logic [2:0] REG_MAXC = 3'd1;
    localparam logic [2:0] REG_PNUM = 3'd2;
    localparam logic [2:0] REG_PDEN = 3'd3;
    localparam logic [2:0] REG_INUM = 3'd4;
    localparam logic [2:0] REG_IDEN = 3'd5;
    localparam logic [2:0] REG_DNUM = 3'd6;
    localparam logic [2:0] REG_DDEN = 3'd7;

    localparam logic [60:0] WIDE_CAP = 61'h1000_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_PMUL, S_PDIV, S_IMUL, S_IDIV, S_ROOT,
        S_DSQ, S_DCUBE, S_DMUL, S_DDIV, S_SUM, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [9:0]  den;
    } t_div_req;
endpackage
`default_nettype wire

// ===== rtl/ddnp_if.sv =====
// Valid/ready channel interfaces for the controller.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ddnp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    modport source (output valid, left_position, right_position, input ready);
    modport sink   (input valid, left_position, right_position, output ready);
endinterface

interface ddnp_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] left_duty;
    logic signed [8:0] right_duty;
    logic signed [7:0] correction;
    modport source (output valid, left_duty, right_duty, correction, input ready);
    modport sink   (input valid, left_duty, right_duty, correction, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddnp_serial_mul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle, saturating at 2^60.
// Uses ddnp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddnp_serial_mul
    import ddnp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [60:0] i_a,
    input  wire logic [60:0] i_b,
    output logic             o_done,
    output logic [60:0]      o_p
);
    logic [60:0] r_a, n_a;
    logic [60:0] r_b, n_b;
    logic [60:0] r_p, n_p;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [61:0] w_sum;
    logic [61:0] w_a2;

    always_comb begin
        w_sum = {1'b0, r_p} + {1'b0, r_a};
        w_a2  = {r_a, 1'b0};
        n_a = r_a; n_b = r_b; n_p = r_p; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_a = i_a; n_b = i_b; n_p = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0])
                n_p = (w_sum > {1'b0, WIDE_CAP}) ? WIDE_CAP : w_sum[60:0];
            n_b = r_b >> 1;
            if (r_b[60:1] != '0 && w_a2 > {1'b0, WIDE_CAP}) n_a = WIDE_CAP;
            else n_a = w_a2[60:0];
            if (r_b[60:1] == '0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_a <= n_a; r_b <= n_b; r_p <= n_p;
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

// ===== rtl/ddnp_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 10-bit divisor.
// Uses ddnp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddnp_serial_div
    import ddnp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_req    i_req,
    output logic             o_done,
    output logic [63:0]      o_q
);
    logic [63:0] r_q, n_q;
    logic [10:0] r_rem, n_rem;
    logic [9:0]  r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [10:0] w_trial;

    always_comb begin
        w_trial = {r_rem[9:0], r_q[63]};
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_q = i_req.num; n_rem = '0; n_cnt = '0; n_busy = 1'b1;
            n_den = (i_req.den == '0) ? 10'd1 : i_req.den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

// ===== rtl/differential_drive_nonlinear_pid.sv =====
// Top level of the differential drive nonlinear PID controller.
// Uses ddnp_pkg, ddnp_if, ddnp_serial_mul and ddnp_serial_div.
`timescale 1ns / 1ps
`default_nettype none
// One sample transaction in, one duty transaction out. Work is serial: a
// shared bit-serial multiplier (one bit of the multiplier per cycle), a shared
// restoring divider and a bit-pair square root. The three gain products and
// the square and cube of the derivative all go through the one multiplier;
// the next sample is taken once the result has left the output register.
// Registers sit at byte addresses 4*i; reads return the value.
module differential_drive_nonlinear_pid
    import ddnp_pkg::*;
#(
    parameter int unsigned ROOT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ddnp_in_if.sink                s_in,
    ddnp_out_if.source             m_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int unsigned RW = 2 * ROOT_BITS;

    logic [6:0] r_base, r_maxc;
    logic [9:0] r_pnum, r_pden, r_inum, r_iden, r_dnum, r_dden;
    logic signed [32:0] r_prev;
    logic signed [39:0] r_integ;

    t_state r_state, n_state;
    logic signed [32:0] r_e;
    logic signed [33:0] r_d;
    logic signed [63:0] r_sum;
    logic [60:0] r_dmag;
    logic [RW-1:0]      r_rv;
    logic [ROOT_BITS-1:0] r_g;
    logic [5:0]  r_rcnt;
    logic        r_started;
    logic signed [8:0] r_ol, r_or;
    logic signed [7:0] r_oc;
    logic        r_ovalid;

    logic        w_wr;
    logic [2:0]  w_idx;
    logic        w_mstart, w_mdone;
    logic [60:0] w_ma, w_mb, w_mp;
    t_div_req    w_dreq;
    logic        w_ddone;
    logic [63:0] w_dq;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_BASE: prdata = {25'd0, r_base};
            REG_MAXC: prdata = {25'd0, r_maxc};
            REG_PNUM: prdata = {22'd0, r_pnum};
            REG_PDEN: prdata = {22'd0, r_pden};
            REG_INUM: prdata = {22'd0, r_inum};
            REG_IDEN: prdata = {22'd0, r_iden};
            REG_DNUM: prdata = {22'd0, r_dnum};
            REG_DDEN: prdata = {22'd0, r_dden};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 7'd20; r_maxc <= 7'd4; r_pnum <= 10'd7; r_pden <= 10'd5;
            r_inum <= 10'd1; r_iden <= 10'd1; r_dnum <= 10'd1; r_dden <= 10'd4;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASE: r_base <= pwdata[6:0];
                REG_MAXC: r_maxc <= pwdata[6:0];
                REG_PNUM: r_pnum <= pwdata[9:0];
                REG_PDEN: r_pden <= pwdata[9:0];
                REG_INUM: r_inum <= pwdata[9:0];
                REG_IDEN: r_iden <= pwdata[9:0];
                REG_DNUM: r_dnum <= pwdata[9:0];
                REG_DDEN: r_dden <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    ddnp_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_p(w_mp)
    );
    ddnp_serial_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
        .o_done(w_ddone), .o_q(w_dq)
    );

    logic        w_accept;
    logic signed [32:0] w_e;
    logic signed [40:0] w_acc;
    logic [32:0] w_emag;
    logic [39:0] w_imag;
    logic [32:0] w_dm;
    logic [RW+1:0] w_x;
    logic [RW-1:0] w_top;
    logic signed [64:0] w_sumx;
    logic signed [8:0]  w_lim;
    logic signed [7:0]  w_corr;
    logic        w_busy;

    assign w_accept = s_in.valid && s_in.ready;
    assign w_busy   = r_started;
    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_e   = 33'(s_in.left_position) - 33'(s_in.right_position);
    assign w_acc = 41'(r_integ) + 41'(w_e);
    assign w_emag = r_e[32] ? 33'(-r_e) : 33'(r_e);
    assign w_imag = r_integ[39] ? 40'(-r_integ) : 40'(r_integ);
    assign w_dm   = r_d[33] ? 33'(-r_d) : 33'(r_d);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_PMUL;
            S_PMUL:  if (w_mdone && r_started) n_state = S_PDIV;
            S_PDIV:  if (w_ddone && r_started) n_state = S_IMUL;
            S_IMUL:  if (w_mdone && r_started) n_state = S_IDIV;
            S_IDIV:  if (w_ddone && r_started) n_state = S_ROOT;
            S_ROOT:  if (r_rcnt == 6'(ROOT_BITS)) n_state = S_DSQ;
            S_DSQ:   if (w_mdone && r_started) n_state = S_DCUBE;
            S_DCUBE: if (w_mdone && r_started) n_state = S_DMUL;
            S_DMUL:  if (w_mdone && r_started) n_state = S_DDIV;
            S_DDIV:  if (w_ddone && r_started) n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mstart = 1'b0; w_ma = '0; w_mb = '0;
        w_dreq = '0;
        unique case (r_state)
            S_PMUL: begin
                w_mstart = !w_busy; w_ma = 61'(w_emag); w_mb = 61'(r_pnum);
            end
            S_IMUL: begin
                w_mstart = !w_busy; w_ma = 61'(w_imag); w_mb = 61'(r_inum);
            end
            S_DSQ: begin
                w_mstart = !w_busy; w_ma = 61'(w_dm); w_mb = 61'(w_dm);
            end
            S_DCUBE: begin
                w_mstart = !w_busy; w_ma = r_dmag; w_mb = 61'(w_dm);
            end
            S_DMUL: begin
                w_mstart = !w_busy; w_ma = r_dmag; w_mb = 61'(r_dnum);
            end
            S_PDIV: begin
                w_dreq.start = !w_busy; w_dreq.num = 64'(r_dmag); w_dreq.den = r_pden;
            end
            S_IDIV: begin
                w_dreq.start = !w_busy; w_dreq.num = 64'(r_dmag); w_dreq.den = r_iden;
            end
            S_DDIV: begin
                w_dreq.start = !w_busy; w_dreq.num = 64'(r_dmag); w_dreq.den = r_dden;
            end
            default: ;
        endcase
    end

    assign w_top = r_rv >> (2 * (ROOT_BITS - 1 - int'(r_rcnt[4:0])));
    assign w_x   = {RW'(r_g), 2'b01};
    assign w_sumx = 65'(r_sum);
    assign w_lim  = 9'(r_maxc);
    assign w_corr = (w_sumx > 65'(w_lim)) ? 8'(r_maxc)
                  : (w_sumx < -65'(w_lim)) ? 8'(-w_lim) : 8'(r_sum);

    logic [RW+1:0] w_rem_sh;
    logic [RW+1:0] w_cmp;
    always_comb begin
        w_cmp = (RW+2)'(w_top);
        w_rem_sh = (RW+2)'(w_x) << (2 * (ROOT_BITS - 1 - int'(r_rcnt[4:0])));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_prev <= '0; r_integ <= '0;
            r_started <= 1'b0; r_ovalid <= 1'b0; r_rcnt <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_started <= 1'b0;
            else if (w_mstart || w_dreq.start) r_started <= 1'b1;
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            if (w_accept) begin
                r_prev  <= w_e;
                r_integ <= (w_acc > 41'sd549755813887) ? 40'sh7F_FFFF_FFFF
                         : (w_acc < -41'sd549755813888) ? 40'sh80_0000_0000
                         : 40'(w_acc);
            end
            if (r_state == S_IDIV && w_ddone && r_started) r_rcnt <= '0;
            else if (r_state == S_ROOT) r_rcnt <= r_rcnt + 6'd1;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
        end
        if (w_accept) begin
            r_e <= w_e;
            r_d <= 34'(w_e) - 34'(r_prev);
        end
        if (w_mdone && r_started) r_dmag <= w_mp;
        case (r_state)
            S_PDIV: if (w_ddone && r_started)
                r_sum <= r_e[32] ? -64'(w_dq) : 64'(w_dq);
            S_IDIV: if (w_ddone && r_started) begin
                r_rv <= (w_dq > 64'hFFFF_FFFF) ? RW'(64'hFFFF_FFFF) : RW'(w_dq);
                r_g  <= '0;
            end
            S_ROOT: if (r_rcnt != 6'(ROOT_BITS)) begin
                if (w_cmp >= w_x) begin
                    r_g  <= {r_g[ROOT_BITS-2:0], 1'b1};
                    r_rv <= r_rv - RW'(w_rem_sh);
                end else begin
                    r_g <= {r_g[ROOT_BITS-2:0], 1'b0};
                end
            end else begin
                r_sum <= r_integ[39] ? r_sum - 64'(r_g) : r_sum + 64'(r_g);
            end
            S_DDIV: if (w_ddone && r_started)
                r_sum <= r_d[33] ? r_sum - 64'(w_dq) : r_sum + 64'(w_dq);
            S_SUM: begin
                r_oc <= w_corr;
                r_ol <= 9'(r_base) - 9'(w_corr);
                r_or <= 9'(r_base) + 9'(w_corr);
            end
            default: ;
        endcase
    end

    assign m_out.valid      = r_ovalid;
    assign m_out.left_duty  = r_ol;
    assign m_out.right_duty = r_or;
    assign m_out.correction = r_oc;

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_IDLE || r_state == S_PMUL)
        else $error("output pending while busy");
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_in.ready)
        else $error("ready while working");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> $stable(m_out.correction))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
